// ===== rtl/asld_pkg.sv =====
package asld_pkg;

    // Defaults for the top-level parameters.
    localparam int VALUE_WIDTH_DEF        = 16;
    localparam int TIME_FRACTION_BITS_DEF = 16;

    // Fixed register widths.
    localparam int RATE_W      = 16;
    localparam int DEAD_BAND_W = 15;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = RATE_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_RATE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECEL_RATE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEAD_BAND  = 2'd2;

    // Word kinds carried on s_tuser.
    localparam logic MODE_STEP = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef struct packed {
        logic [RATE_W-1:0]      accel_rate;
        logic [RATE_W-1:0]      decel_rate;
        logic [DEAD_BAND_W-1:0] dead_band;
    } cfg_t;

endpackage

// ===== rtl/asld_step.sv =====
module asld_step #(
    parameter int VALUE_WIDTH        = asld_pkg::VALUE_WIDTH_DEF,
    parameter int TIME_FRACTION_BITS = asld_pkg::TIME_FRACTION_BITS_DEF
) (
    input  asld_pkg::cfg_t                 cfg,
    input  logic                           mode,
    input  logic signed [VALUE_WIDTH-1:0]  target,
    input  logic [TIME_FRACTION_BITS-1:0]  time_step,
    input  logic signed [VALUE_WIDTH-1:0]  cur_value,
    output logic signed [VALUE_WIDTH-1:0]  next_value
);
    import asld_pkg::*;

    // Internal width holds magnitudes, differences and the 16-bit step with room for sign.
    localparam int EW     = ((VALUE_WIDTH > RATE_W) ? VALUE_WIDTH : RATE_W) + 2;
    localparam int PROD_W = RATE_W + TIME_FRACTION_BITS;
    localparam logic signed [EW-1:0] VAL_MAX =
        EW'((longint'(1) << (VALUE_WIDTH - 1)) - longint'(1));

    function automatic logic signed [EW-1:0] abs_e(input logic signed [EW-1:0] x);
        return (x < 0) ? -x : x;
    endfunction

    logic signed [EW-1:0] tgt_e;
    logic signed [EW-1:0] cur_e;
    logic signed [EW-1:0] db_raw;
    logic signed [EW-1:0] db_e;
    logic signed [EW-1:0] tgt_mag;
    logic signed [EW-1:0] cur_mag;
    logic signed [EW-1:0] edge_e;
    logic signed [EW-1:0] start_e;
    logic signed [EW-1:0] diff_e;
    logic signed [EW-1:0] step_e;
    logic signed [EW-1:0] moved_e;
    logic                 cur_in;
    logic                 tgt_in;
    logic [RATE_W-1:0]    rate;
    logic [PROD_W-1:0]    product;
    logic [RATE_W-1:0]    step;

    always_comb begin
        tgt_e   = EW'(target);
        cur_e   = EW'(cur_value);
        db_raw  = $signed({{(EW-DEAD_BAND_W){1'b0}}, cfg.dead_band});
        db_e    = (db_raw > VAL_MAX) ? VAL_MAX : db_raw;
        tgt_mag = abs_e(tgt_e);
        cur_mag = abs_e(cur_e);
        cur_in  = (cur_mag <= db_e);
        tgt_in  = (tgt_mag <= db_e);

        // Leaving the deadzone starts from its edge on the target's side.
        edge_e  = (tgt_e > 0) ? db_e : -db_e;
        start_e = cur_in ? edge_e : cur_e;

        rate    = (tgt_mag > abs_e(start_e)) ? cfg.accel_rate : cfg.decel_rate;
        product = PROD_W'(rate) * PROD_W'(time_step);
        // The shifted product never exceeds 16 bits, so the 65535 ceiling holds by width.
        step    = product[PROD_W-1:TIME_FRACTION_BITS];
        step_e  = $signed({{(EW-RATE_W){1'b0}}, step});

        diff_e  = tgt_e - start_e;
        moved_e = (diff_e > 0) ? (start_e + step_e) : (start_e - step_e);

        if (mode == MODE_LOAD) begin
            next_value = target;
        end else if (cur_in && tgt_in) begin
            next_value = target;
        end else if (abs_e(diff_e) <= step_e) begin
            next_value = target;
        end else begin
            next_value = moved_e[VALUE_WIDTH-1:0];
        end
    end

endmodule

// ===== rtl/asymmetric_slew_limiter_deadzone.sv =====
// A word accepted into the input register has its result in value_reg, shown on m_tdata
// with m_tvalid high, once the output register is free to take it.
// Throughput: one word per cycle unless m_tready stalls; the rate-select, multiply and add
// path is combinational on the held output register; words wait only on back-pressure.
// Reset (aresetn low, sync): both stages empty, value, cfg and output zero; input data kept.
module asymmetric_slew_limiter_deadzone #(
    parameter int VALUE_WIDTH        = asld_pkg::VALUE_WIDTH_DEF,
    parameter int TIME_FRACTION_BITS = asld_pkg::TIME_FRACTION_BITS_DEF
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  cfg_wr_en,
    input  logic [asld_pkg::CFG_ADDR_W-1:0]                       cfg_addr,
    input  logic [asld_pkg::CFG_DATA_W-1:0]                       cfg_wdata,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // s_tdata: target, then time_step, zero padding to whole bytes
    input  logic [((VALUE_WIDTH+TIME_FRACTION_BITS+7)/8)*8-1:0]   s_tdata,
    // s_tuser: mode
    input  logic                                                  s_tuser,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // m_tdata: value, zero padding to whole bytes
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]                      m_tdata
);
    import asld_pkg::*;

    localparam int M_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    cfg_t                           cfg_reg;
    logic                           in_valid_reg;
    logic                           in_mode_reg;
    logic signed [VALUE_WIDTH-1:0]  in_target_reg;
    logic [TIME_FRACTION_BITS-1:0]  in_tstep_reg;
    logic                           out_valid_reg;
    // Holds both the limiter state and the result word shown on m_tdata.
    logic signed [VALUE_WIDTH-1:0]  value_reg;

    logic                           in_valid_next;
    logic                           out_valid_next;
    logic signed [VALUE_WIDTH-1:0]  value_next;
    logic signed [VALUE_WIDTH-1:0]  step_value;
    logic                           out_free;
    logic                           advance;
    logic                           s_accept;

    asld_step #(
        .VALUE_WIDTH        (VALUE_WIDTH),
        .TIME_FRACTION_BITS (TIME_FRACTION_BITS)
    ) u_step (
        .cfg        (cfg_reg),
        .mode       (in_mode_reg),
        .target     (in_target_reg),
        .time_step  (in_tstep_reg),
        .cur_value  (value_reg),
        .next_value (step_value)
    );

    always_comb begin
        out_free = !out_valid_reg || m_tready;
        advance  = in_valid_reg && out_free;
        s_tready = !in_valid_reg || out_free;
        s_accept = s_tvalid && s_tready;

        in_valid_next  = s_accept || (in_valid_reg && !out_free);
        out_valid_next = advance || (out_valid_reg && !m_tready);
        value_next     = advance ? step_value : value_reg;

        m_tvalid = out_valid_reg;
        m_tdata  = M_TDATA_W'($unsigned(value_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            cfg_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_ACCEL_RATE: begin
                        cfg_reg.accel_rate <= cfg_wdata[RATE_W-1:0];
                    end
                    CFG_DECEL_RATE: begin
                        cfg_reg.decel_rate <= cfg_wdata[RATE_W-1:0];
                    end
                    CFG_DEAD_BAND: begin
                        cfg_reg.dead_band <= cfg_wdata[DEAD_BAND_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg   <= s_tuser;
            in_target_reg <= s_tdata[VALUE_WIDTH-1:0];
            in_tstep_reg  <= s_tdata[VALUE_WIDTH+TIME_FRACTION_BITS-1:VALUE_WIDTH];
        end
    end

endmodule
